>>> design/diset_pkg.sv
package diset_pkg;

	localparam int DefCapacity = 64;
	localparam int DefValueBits = 63;
	localparam int MexBits = 64;

	localparam logic [1:0] OP_QUERY = 2'd0;
	localparam logic [1:0] OP_ADD = 2'd1;
	localparam logic [1:0] OP_ERASE = 2'd2;
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic was_member;
		logic [MexBits-1:0] mex;
		logic overflow;
	} result_t;

endpackage

>>> design/disjoint_interval_integer_set.sv
// Disjoint interval integer set.
// Input channel (in_valid/in_ready): opcode (query, add, erase) and a signed value.
// Output channel (out_valid/out_ready): was_member, mex_from_value and overflow,
// one result item for every input item, in order.
// The interval table lives in one synchronous RAM of CAPACITY entries.
// An item is located by a binary search over the table; each probe reads the
// RAM in S_SRCH_RD and compares in S_SRCH_CMP, as the RAM read is registered.
// The neighbor entries are fetched in S_PRV_RD, S_PRV_CAP and S_NXT_CAP, and
// the update is decided in S_DECIDE. An insert or removal then shifts the
// entries behind the touched slot, one entry per cycle through the single
// write port, followed by the last pending write and, for an insert, the
// write of the new entry. One item is worked on at a time; the next item is
// accepted in the cycle after the result is handed on.
// The result is held in an output register, so the next item is accepted
// while an earlier result still waits; if that register is still full when
// a new result is ready, the block waits until out_ready frees it.
// Reset (arst_n low) empties the set at once; the RAM needs no clearing.
module disjoint_interval_integer_set #(
	parameter int CAPACITY = diset_pkg::DefCapacity,
	parameter int VALUE_BITS = diset_pkg::DefValueBits
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] opcode,
	input  logic [VALUE_BITS-1:0] value,
	output logic out_valid,
	input  logic out_ready,
	output logic was_member,
	output logic [diset_pkg::MexBits-1:0] mex_from_value,
	output logic overflow
);

	localparam int AW = $clog2(CAPACITY);

	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [2*VALUE_BITS-1:0] mem_wdata, mem_rdata;
	logic res_valid, res_free;
	diset_pkg::result_t res;
	diset_pkg::result_t out_q;
	logic out_valid_q;

	diset_ram #(
		.WIDTH(2*VALUE_BITS),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	diset_ctrl #(
		.CAPACITY(CAPACITY),
		.VALUE_BITS(VALUE_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.value(value),
		.res_free(res_free),
		.res_valid(res_valid),
		.res(res),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	assign res_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign was_member = out_q.was_member;
	assign mex_from_value = out_q.mex;
	assign overflow = out_q.overflow;

endmodule

>>> design/diset_ram.sv
module diset_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/diset_ctrl.sv
module diset_ctrl #(
	parameter int CAPACITY = diset_pkg::DefCapacity,
	parameter int VALUE_BITS = diset_pkg::DefValueBits
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] opcode,
	input  logic [VALUE_BITS-1:0] value,
	input  logic res_free,
	output logic res_valid,
	output diset_pkg::result_t res,
	output logic mem_we,
	output logic [$clog2(CAPACITY)-1:0] mem_waddr,
	output logic [2*VALUE_BITS-1:0] mem_wdata,
	output logic [$clog2(CAPACITY)-1:0] mem_raddr,
	input  logic [2*VALUE_BITS-1:0] mem_rdata
);

	localparam int VB = VALUE_BITS;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CapCount = CW'(CAPACITY);
	localparam logic [CW-1:0] One = CW'(1);

	typedef enum logic [2:0] {
		S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_PRV_RD, S_PRV_CAP, S_NXT_CAP, S_DECIDE, S_SHIFT
	} state_t;

	typedef enum logic [1:0] {SH_NONE, SH_INS, SH_REM} shift_t;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [1:0] op_q;
	logic [VB-1:0] x_q;
	logic [CW-1:0] lo_q, hi_q;
	logic [VB-1:0] p_low_q, p_high_q, n_low_q, n_high_q;
	shift_t sh_mode_q;
	logic [CW-1:0] rp_q, left_q;
	logic [AW-1:0] wa_q, ins_idx_q;
	logic [2*VB-1:0] ins_data_q;
	logic pend_q;
	diset_pkg::result_t res_q;

	logic [CW:0] mid_sum;
	logic [CW-1:0] mid;
	logic [VB-1:0] rd_low, rd_high;

	// Decision signals.
	logic has_prev, has_next, member, left_adj, right_adj, full;
	logic [CW-1:0] nxt, pidx;
	logic d_we;
	logic [AW-1:0] d_waddr;
	logic [2*VB-1:0] d_wdata;
	logic d_ovf;
	shift_t d_mode;
	logic [CW-1:0] d_idx, d_count;
	logic [2*VB-1:0] d_ins;
	logic [VB-1:0] x_inc, x_dec;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = mid_sum[CW:1];
	assign rd_low = mem_rdata[2*VB-1:VB];
	assign rd_high = mem_rdata[VB-1:0];

	assign nxt = lo_q;
	assign pidx = lo_q - One;
	assign has_prev = (nxt != '0);
	assign has_next = (nxt < count_q);
	assign member = has_prev && ($signed(x_q) <= $signed(p_high_q));
	assign left_adj = has_prev && (({p_high_q[VB-1], p_high_q} + (VB+1)'(1)) == {x_q[VB-1], x_q});
	assign right_adj = has_next && (({x_q[VB-1], x_q} + (VB+1)'(1)) == {n_low_q[VB-1], n_low_q});
	assign full = (count_q == CapCount);
	assign x_inc = x_q + VB'(1);
	assign x_dec = x_q - VB'(1);

	always_comb begin
		d_we = 1'b0;
		d_waddr = pidx[AW-1:0];
		d_wdata = {p_low_q, p_high_q};
		d_ovf = 1'b0;
		d_mode = SH_NONE;
		d_idx = nxt;
		d_count = count_q;
		d_ins = {x_q, x_q};
		if (op_q == diset_pkg::OP_ADD && !member) begin
			if (left_adj && right_adj) begin
				d_we = 1'b1;
				d_wdata = {p_low_q, n_high_q};
				d_mode = SH_REM;
				d_count = count_q - One;
			end else if (left_adj) begin
				d_we = 1'b1;
				d_wdata = {p_low_q, x_q};
			end else if (right_adj) begin
				d_we = 1'b1;
				d_waddr = nxt[AW-1:0];
				d_wdata = {x_q, n_high_q};
			end else if (full) begin
				d_ovf = 1'b1;
			end else begin
				d_mode = SH_INS;
				d_count = count_q + One;
			end
		end else if (op_q == diset_pkg::OP_ERASE && member) begin
			if (p_low_q == x_q && p_high_q == x_q) begin
				d_mode = SH_REM;
				d_idx = pidx;
				d_count = count_q - One;
			end else if (p_low_q == x_q) begin
				d_we = 1'b1;
				d_wdata = {x_inc, p_high_q};
			end else if (p_high_q == x_q) begin
				d_we = 1'b1;
				d_wdata = {p_low_q, x_dec};
			end else if (full) begin
				d_ovf = 1'b1;
			end else begin
				// Split: the lower part stays in place, the upper part is inserted after it.
				d_we = 1'b1;
				d_wdata = {p_low_q, x_dec};
				d_mode = SH_INS;
				d_idx = nxt;
				d_ins = {x_inc, p_high_q};
				d_count = count_q + One;
			end
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = wa_q;
		mem_wdata = mem_rdata;
		mem_raddr = rp_q[AW-1:0];
		unique case (state_q)
			S_SRCH_RD: mem_raddr = mid[AW-1:0];
			S_PRV_RD: mem_raddr = pidx[AW-1:0];
			S_PRV_CAP: mem_raddr = nxt[AW-1:0];
			S_DECIDE: begin
				mem_we = d_we;
				mem_waddr = d_waddr;
				mem_wdata = d_wdata;
			end
			S_SHIFT: begin
				if (pend_q) begin
					mem_we = 1'b1;
				end else if (left_q == '0 && sh_mode_q == SH_INS) begin
					mem_we = 1'b1;
					mem_waddr = ins_idx_q;
					mem_wdata = ins_data_q;
				end
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	assign res = res_q;
	assign res_valid = (state_q == S_SHIFT) && !pend_q && left_q == '0 && res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_q <= 1'b0;
			left_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= opcode;
						x_q <= value;
						lo_q <= '0;
						hi_q <= count_q;
						state_q <= S_SRCH_RD;
					end
				end
				S_SRCH_RD: begin
					state_q <= (lo_q < hi_q) ? S_SRCH_CMP : S_PRV_RD;
				end
				S_SRCH_CMP: begin
					if ($signed(rd_low) <= $signed(x_q)) begin
						lo_q <= mid + One;
					end else begin
						hi_q <= mid;
					end
					state_q <= S_SRCH_RD;
				end
				S_PRV_RD: state_q <= S_PRV_CAP;
				S_PRV_CAP: begin
					p_low_q <= rd_low;
					p_high_q <= rd_high;
					state_q <= S_NXT_CAP;
				end
				S_NXT_CAP: begin
					n_low_q <= rd_low;
					n_high_q <= rd_high;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					res_q.was_member <= member;
					res_q.mex <= member ?
						diset_pkg::MexBits'($signed(p_high_q)) + diset_pkg::MexBits'(1) :
						diset_pkg::MexBits'($signed(x_q));
					res_q.overflow <= d_ovf;
					count_q <= d_count;
					sh_mode_q <= d_mode;
					ins_idx_q <= d_idx[AW-1:0];
					ins_data_q <= d_ins;
					pend_q <= 1'b0;
					if (d_mode == SH_INS) begin
						rp_q <= count_q - One;
						left_q <= count_q - d_idx;
					end else if (d_mode == SH_REM) begin
						rp_q <= d_idx + One;
						left_q <= count_q - One - d_idx;
					end else begin
						left_q <= '0;
					end
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (left_q != '0) begin
						pend_q <= 1'b1;
						left_q <= left_q - One;
						if (sh_mode_q == SH_INS) begin
							wa_q <= AW'(rp_q + One);
							rp_q <= rp_q - One;
						end else begin
							wa_q <= AW'(rp_q - One);
							rp_q <= rp_q + One;
						end
					end else if (pend_q) begin
						pend_q <= 1'b0;
					end else begin
						// The final insert write (if any) happens in this cycle.
						sh_mode_q <= SH_NONE;
						if (res_free) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
